// ----- rtl/core/bee_pkg.sv -----
// Package for the beam edge end adjust block: payload structs, register codes,
// reset values and the address width. No dependencies.
`timescale 1ns / 1ps

package bee_pkg;

  // One input word: beam geometry and camera angle.
  typedef struct packed {
    logic        [47:0] beam_dir_packed;
    logic        [47:0] cam_dir_packed;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
    logic        [30:0] beam_length;
    logic signed [15:0] cam_angle;
  } item_t;

  // One result word.
  typedef struct packed {
    logic signed [31:0] render_x;
    logic signed [31:0] render_y;
    logic signed [31:0] render_z;
    logic               on_edge;
    logic               adjusted;
  } result_t;

  // Queue entry: the input word plus the front-end classification.
  typedef struct packed {
    item_t item;
    logic  adjusted;
  } entry_t;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] RegTolerance = 2'd0;
  localparam logic [1:0] RegEpsilon   = 2'd1;
  localparam logic [1:0] RegAdjust    = 2'd2;

  localparam int unsigned AddrW = 4;

  localparam logic signed [15:0] TolReset = 16'sd1638;
  localparam logic [14:0]        EpsReset = 15'd16;
  localparam logic [14:0]        AdjReset = 15'd1638;

endpackage

// ----- rtl/core/beam_edge_end_adjust_top.sv -----
// Top level of the beam edge end adjust block: configuration registers,
// front end, queue and back end. Depends on bee_pkg, bee_front, bee_fifo,
// bee_back.
`timescale 1ns / 1ps

// Channel       Direction  Handshake                       Word
// ------------  ---------  ------------------------------  ----------------
// command       in         start high, busy low            item_i (item_t)
// result        out        res_vld_o strobe, one cycle     result_o
// config (APB)  in/out     psel, penable, pwrite, pready   pwdata / prdata
//
// A new word is taken every cycle while busy is low; its result passes the
// front register and the queue, 7 single stages, square roots of 18 and 24
// and two dividers.
// Reset clears all valid flags and loads the register reset values. The result
// side cannot push back, so the back end drains the queue every cycle and busy
// only rises if the queue were to fill.

module beam_edge_end_adjust_top #(
  parameter int unsigned QDepth = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  bee_pkg::item_t                item_i,
  output logic                          res_vld_o,
  output bee_pkg::result_t              result_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bee_pkg::AddrW-1:0]     paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  import bee_pkg::*;

  // Configuration registers. Writes are only expected while the block is
  // idle, so the datapath reads them directly.
  logic signed [15:0] tol_q, tol_d;
  logic [14:0]        eps_q, eps_d;
  logic [14:0]        adj_q, adj_d;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    tol_d = tol_q;
    eps_d = eps_q;
    adj_d = adj_q;
    if (cfg_wr) begin
      unique case (paddr[3:2])
        RegTolerance: tol_d = $signed(pwdata[15:0]);
        RegEpsilon:   eps_d = pwdata[14:0];
        RegAdjust:    adj_d = pwdata[14:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolReset;
      eps_q <= EpsReset;
      adj_q <= AdjReset;
    end else begin
      tol_q <= tol_d;
      eps_q <= eps_d;
      adj_q <= adj_d;
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegTolerance: prdata = 32'(tol_q);
      RegEpsilon:   prdata = {17'd0, eps_q};
      RegAdjust:    prdata = {17'd0, adj_q};
      default:      prdata = '0;
    endcase
  end

  // Front end classifies each word against the tolerance.
  logic   front_vld;
  entry_t front_ent;
  logic   fifo_full;

  bee_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .item_i  (item_i),
    .tol_i   (tol_q),
    .full_i  (fifo_full),
    .busy_o  (busy),
    .vld_o   (front_vld),
    .ent_o   (front_ent)
  );

  // Queue decouples the two halves.
  logic   q_vld;
  entry_t q_ent;

  bee_fifo #(
    .Depth(QDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (front_vld),
    .ent_i  (front_ent),
    .full_o (fifo_full),
    .vld_o  (q_vld),
    .ent_o  (q_ent)
  );

  // Back end computes the render end.
  bee_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (q_vld),
    .ent_i  (q_ent),
    .eps_i  (eps_q),
    .adj_i  (adj_q),
    .vld_o  (res_vld_o),
    .res_o  (result_o)
  );

`ifndef NO_ASSERTIONS
  // An accepted word must be held by the front end in the next cycle.
  a_accept_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> front_vld)
    else $error("accepted word not captured by the front end");

  // A word stuck behind a full queue must not be dropped.
  a_stall_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (front_vld && fifo_full) |=> front_vld)
    else $error("front end word lost while the queue was full");

  // The edge flag only exists for adjusted beams.
  a_edge_adj: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_o |-> (!result_o.on_edge || result_o.adjusted))
    else $error("on_edge set on a beam that was not adjusted");
`endif

endmodule

// ----- rtl/core/bee_isqrt.sv -----
// Pipelined floor square root, one result bit per stage, with a sideband tag.
// Depends on nothing.
`timescale 1ns / 1ps

module bee_isqrt #(
  parameter int unsigned XW = 34,
  parameter int unsigned TW = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    vld_i,
  input  logic [XW-1:0]           x_i,
  input  logic [TW-1:0]           tag_i,
  output logic                    vld_o,
  output logic [(XW+1)/2-1:0]     root_o,
  output logic [TW-1:0]           tag_o
);

  localparam int unsigned P  = (XW + 1) / 2;
  localparam int unsigned RW = P + 2;

  logic [2*P-1:0] x_q    [P+1];
  logic [RW-1:0]  rem_q  [P+1];
  logic [P-1:0]   root_q [P+1];
  logic [TW-1:0]  tag_q  [P+1];
  logic           vld_q  [P+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]    <= (2*P)'(x_i);
    rem_q[0]  <= '0;
    root_q[0] <= '0;
    tag_q[0]  <= tag_i;
  end

  for (genvar s = 1; s <= P; s++) begin : g_stage
    logic [RW+1:0] tmp;
    logic [RW+1:0] trial;
    logic          take;

    always_comb begin
      tmp   = {rem_q[s-1], x_q[s-1][2*(P-s) +: 2]};
      trial = {2'b00, root_q[s-1], 2'b01};
      take  = (tmp >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      x_q[s]   <= x_q[s-1];
      tag_q[s] <= tag_q[s-1];
      if (take) begin
        rem_q[s]  <= RW'(tmp - trial);
        root_q[s] <= P'({root_q[s-1], 1'b1});
      end else begin
        rem_q[s]  <= RW'(tmp);
        root_q[s] <= P'({root_q[s-1], 1'b0});
      end
    end
  end

  assign vld_o  = vld_q[P];
  assign root_o = root_q[P];
  assign tag_o  = tag_q[P];

endmodule

// ----- rtl/core/bee_rdiv.sv -----
// Pipelined three-lane signed divider by a shared unsigned divisor, rounding
// half away from zero, one quotient bit per stage. Depends on nothing.
`timescale 1ns / 1ps

module bee_rdiv #(
  parameter int unsigned NW = 31,
  parameter int unsigned DW = 17,
  parameter int unsigned QW = 15,
  parameter int unsigned TW = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  vld_i,
  input  logic [2:0][NW-1:0]    num_i,
  input  logic [DW-1:0]         den_i,
  input  logic [TW-1:0]         tag_i,
  output logic                  vld_o,
  output logic [2:0][QW:0]      quo_o,
  output logic [TW-1:0]         tag_o
);

  localparam int unsigned RW = NW + 1;
  localparam int unsigned CW = (RW > DW + QW) ? RW : DW + QW;

  logic [CW-1:0] rem_q [QW+1][3];
  logic [QW-1:0] quo_q [QW+1][3];
  logic          neg_q [QW+1][3];
  logic [DW-1:0] den_q [QW+1];
  logic [TW-1:0] tag_q [QW+1];
  logic          vld_q [QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= vld_i;
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_in
    logic signed [CW-1:0] numx;
    logic [CW-1:0]        mag;

    always_comb begin
      numx = CW'($signed(num_i[l]));
      mag  = numx[CW-1] ? CW'(-numx) : CW'(numx);
    end

    // Adding half the divisor up front turns the floor division into rounding.
    always_ff @(posedge clk_i) begin
      rem_q[0][l] <= mag + CW'(den_i >> 1);
      quo_q[0][l] <= '0;
      neg_q[0][l] <= numx[CW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    den_q[0] <= den_i;
    tag_q[0] <= tag_i;
  end

  for (genvar s = 1; s <= QW; s++) begin : g_stage
    logic [CW-1:0] sub;

    assign sub = CW'(den_q[s-1]) << (QW - s);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      den_q[s] <= den_q[s-1];
      tag_q[s] <= tag_q[s-1];
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      always_ff @(posedge clk_i) begin
        neg_q[s][l] <= neg_q[s-1][l];
        if (rem_q[s-1][l] >= sub) begin
          rem_q[s][l] <= rem_q[s-1][l] - sub;
          quo_q[s][l] <= quo_q[s-1][l] | (QW'(1) << (QW - s));
        end else begin
          rem_q[s][l] <= rem_q[s-1][l];
          quo_q[s][l] <= quo_q[s-1][l];
        end
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_out
    assign quo_o[l] = neg_q[QW][l] ? (QW+1)'(-{1'b0, quo_q[QW][l]})
                                   : {1'b0, quo_q[QW][l]};
  end

  assign vld_o = vld_q[QW];
  assign tag_o = tag_q[QW];

endmodule

// ----- rtl/core/bee_front.sv -----
// Front end: takes one input word, classifies it against the tolerance and
// holds it until the queue has room. Depends on bee_pkg.
`timescale 1ns / 1ps

module bee_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  bee_pkg::item_t            item_i,
  input  logic signed [15:0]        tol_i,
  input  logic                      full_i,
  output logic                      busy_o,
  output logic                      vld_o,
  output bee_pkg::entry_t           ent_o
);

  import bee_pkg::*;

  logic   vld_q, vld_d;
  entry_t ent_q;
  logic   accept;

  assign busy_o = vld_q & full_i;
  assign accept = start_i & ~busy_o;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (vld_q && !full_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ent_q.item     <= item_i;
      ent_q.adjusted <= (item_i.cam_angle < tol_i);
    end
  end

  assign vld_o = vld_q;
  assign ent_o = ent_q;

endmodule

// ----- rtl/core/bee_fifo.sv -----
// Short queue between front and back end; the back end drains one entry
// per cycle whenever one is present. Depends on bee_pkg.
`timescale 1ns / 1ps

module bee_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  input  bee_pkg::entry_t ent_i,
  output logic            full_o,
  output logic            vld_o,
  output bee_pkg::entry_t ent_o
);

  import bee_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t          mem [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign full_o = (cnt_q == CntW'(Depth));
  assign vld_o  = (cnt_q != '0);
  assign push   = vld_i & ~full_o;
  assign pop    = vld_o;
  assign ent_o  = mem[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[wr_q] <= ent_i;
    end
  end

endmodule

// ----- rtl/core/bee_back.sv -----
// Back end: fixed-latency pipeline that forms the offset, normalizes it,
// bends the direction and computes the saturated render end or, for a beam
// that is not adjusted, the true end. Depends on bee_pkg, bee_isqrt and bee_rdiv.
`timescale 1ns / 1ps

module bee_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             vld_i,
  input  bee_pkg::entry_t  ent_i,
  input  logic [14:0]      eps_i,
  input  logic [14:0]      adj_i,
  output logic             vld_o,
  output bee_pkg::result_t res_o
);

  import bee_pkg::*;

  typedef struct packed {
    logic [2:0][31:0] start;
    logic [2:0][31:0] endp;
    logic [30:0]      len;
    logic [47:0]      dir;
    logic             adj;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [2:0][16:0] diff;
  } t1_t;

  typedef struct packed {
    side_t       side;
    logic [16:0] off;
    logic        edge_f;
  } t2_t;

  typedef struct packed {
    side_t            side;
    logic             edge_f;
    logic [2:0][21:0] nd;
  } t3_t;

  typedef struct packed {
    side_t side;
    logic  edge_f;
    logic  nlz;
  } t4_t;

  // Shift right by 14 with the magnitude rounded half away from zero.
  function automatic logic signed [47:0] rshr14(input logic signed [47:0] v);
    logic [47:0] mag;
    logic [47:0] q;
    mag = v[47] ? 48'(-v) : 48'(v);
    q   = (mag + 48'd8192) >> 14;
    return v[47] ? -$signed(q) : $signed(q);
  endfunction

  // Stage A: offset and its squares.
  side_t               side_c;
  logic signed [16:0]  diff_c [3];
  logic [16:0]         dabs_c [3];
  logic                a_vld_q;
  side_t               a_side_q;
  logic [2:0][16:0]    a_diff_q;
  logic [32:0]         a_sq_q [3];

  always_comb begin
    side_c.start = {ent_i.item.start_z, ent_i.item.start_y, ent_i.item.start_x};
    side_c.endp  = {ent_i.item.end_z, ent_i.item.end_y, ent_i.item.end_x};
    side_c.len   = ent_i.item.beam_length;
    side_c.dir   = ent_i.item.beam_dir_packed;
    side_c.adj   = ent_i.adjusted;
    for (int l = 0; l < 3; l++) begin
      diff_c[l] = 17'($signed(ent_i.item.beam_dir_packed[16*l +: 16]))
                + 17'($signed(ent_i.item.cam_dir_packed[16*l +: 16]));
      dabs_c[l] = diff_c[l][16] ? 17'(-diff_c[l]) : 17'(diff_c[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_side_q <= side_c;
    for (int l = 0; l < 3; l++) begin
      a_diff_q[l] <= diff_c[l];
      a_sq_q[l]   <= 33'(dabs_c[l]) * 33'(dabs_c[l]);
    end
  end

  // Offset length.
  t1_t         t1_in, t1_out;
  logic        s1_vld;
  logic [16:0] off;

  assign t1_in.side = a_side_q;
  assign t1_in.diff = a_diff_q;

  bee_isqrt #(
    .XW(34),
    .TW($bits(t1_t))
  ) u_sqrt_off (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (a_vld_q),
    .x_i    (34'(a_sq_q[0]) + 34'(a_sq_q[1]) + 34'(a_sq_q[2])),
    .tag_i  (t1_in),
    .vld_o  (s1_vld),
    .root_o (off),
    .tag_o  (t1_out)
  );

  // Offset normalization.
  t2_t              t2_in, t2_out;
  logic [2:0][30:0] num1;
  logic             d1_vld;
  logic [2:0][15:0] quo1;

  always_comb begin
    t2_in.side   = t1_out.side;
    t2_in.off    = off;
    t2_in.edge_f = (off <= 17'(eps_i));
    for (int l = 0; l < 3; l++) begin
      num1[l] = {t1_out.diff[l], 14'b0};
    end
  end

  bee_rdiv #(
    .NW(31),
    .DW(17),
    .QW(15),
    .TW($bits(t2_t))
  ) u_div_off (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (s1_vld),
    .num_i  (num1),
    .den_i  (off),
    .tag_i  (t2_in),
    .vld_o  (d1_vld),
    .quo_o  (quo1),
    .tag_o  (t2_out)
  );

  // Stage B: zero the offset on edge and form the scale.
  logic               b_vld_q;
  side_t              b_side_q;
  logic               b_edge_q;
  logic signed [15:0] b_dn_q [3];
  logic signed [17:0] b_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= d1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    b_side_q  <= t2_out.side;
    b_edge_q  <= t2_out.edge_f;
    b_scale_q <= $signed({3'b000, adj_i})
               - $signed({1'b0, (t2_out.edge_f ? 17'd0 : t2_out.off)});
    for (int l = 0; l < 3; l++) begin
      b_dn_q[l] <= t2_out.edge_f ? 16'sd0 : $signed(quo1[l]);
    end
  end

  // Stage C: scaled offset.
  logic               c_vld_q;
  side_t              c_side_q;
  logic               c_edge_q;
  logic signed [33:0] c_prod_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_side_q <= b_side_q;
    c_edge_q <= b_edge_q;
    for (int l = 0; l < 3; l++) begin
      c_prod_q[l] <= 34'(b_dn_q[l]) * 34'(b_scale_q);
    end
  end

  // Stage D: bent direction.
  logic               d_vld_q;
  side_t              d_side_q;
  logic               d_edge_q;
  logic signed [21:0] d_nd_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else begin
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d_side_q <= c_side_q;
    d_edge_q <= c_edge_q;
    for (int l = 0; l < 3; l++) begin
      d_nd_q[l] <= 22'($signed(c_side_q.dir[16*l +: 16]))
                 + 22'(rshr14(48'(c_prod_q[l])));
    end
  end

  // Stage E: squares of the bent direction.
  logic             e_vld_q;
  side_t            e_side_q;
  logic             e_edge_q;
  logic [2:0][21:0] e_nd_q;
  logic [43:0]      e_sq_q [3];
  logic [21:0]      ndabs [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      ndabs[l] = d_nd_q[l][21] ? 22'(-d_nd_q[l]) : 22'(d_nd_q[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else begin
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e_side_q <= d_side_q;
    e_edge_q <= d_edge_q;
    for (int l = 0; l < 3; l++) begin
      e_nd_q[l] <= d_nd_q[l];
      e_sq_q[l] <= 44'(ndabs[l]) * 44'(ndabs[l]);
    end
  end

  // Direction length.
  t3_t         t3_in, t3_out;
  logic        s2_vld;
  logic [22:0] nl;

  assign t3_in.side   = e_side_q;
  assign t3_in.edge_f = e_edge_q;
  assign t3_in.nd     = e_nd_q;

  bee_isqrt #(
    .XW(46),
    .TW($bits(t3_t))
  ) u_sqrt_dir (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (e_vld_q),
    .x_i    (46'(e_sq_q[0]) + 46'(e_sq_q[1]) + 46'(e_sq_q[2])),
    .tag_i  (t3_in),
    .vld_o  (s2_vld),
    .root_o (nl),
    .tag_o  (t3_out)
  );

  // Direction normalization.
  t4_t              t4_in, t4_out;
  logic [2:0][35:0] num2;
  logic             d2_vld;
  logic [2:0][15:0] quo2;

  always_comb begin
    t4_in.side   = t3_out.side;
    t4_in.edge_f = t3_out.edge_f;
    t4_in.nlz    = (nl == '0);
    for (int l = 0; l < 3; l++) begin
      num2[l] = {t3_out.nd[l], 14'b0};
    end
  end

  bee_rdiv #(
    .NW(36),
    .DW(23),
    .QW(15),
    .TW($bits(t4_t))
  ) u_div_dir (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (s2_vld),
    .num_i  (num2),
    .den_i  (nl),
    .tag_i  (t4_in),
    .vld_o  (d2_vld),
    .quo_o  (quo2),
    .tag_o  (t4_out)
  );

  // Stage F: direction times length. A zero direction stays zero.
  logic               f_vld_q;
  side_t              f_side_q;
  logic               f_edge_q;
  logic signed [47:0] f_prod_q [3];
  logic signed [15:0] ndn [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      ndn[l] = t4_out.nlz ? 16'sd0 : $signed(quo2[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else begin
      f_vld_q <= d2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    f_side_q <= t4_out.side;
    f_edge_q <= t4_out.edge_f;
    for (int l = 0; l < 3; l++) begin
      f_prod_q[l] <= 48'(ndn[l]) * $signed({17'd0, t4_out.side.len});
    end
  end

  // Stage G: add start, saturate, choose against the true end.
  logic               g_vld_q;
  result_t            g_res_q;
  logic signed [34:0] sum [3];
  logic signed [31:0] sat [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      sum[l] = 35'($signed(f_side_q.start[l])) + 35'(rshr14(f_prod_q[l]));
      if (sum[l] > 35'sd2147483647) begin
        sat[l] = 32'sh7fffffff;
      end else if (sum[l] < -35'sd2147483648) begin
        sat[l] = 32'sh80000000;
      end else begin
        sat[l] = 32'(sum[l]);
      end
      if (!f_side_q.adj) begin
        sat[l] = $signed(f_side_q.endp[l]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q <= 1'b0;
    end else begin
      g_vld_q <= f_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    g_res_q.render_x <= sat[0];
    g_res_q.render_y <= sat[1];
    g_res_q.render_z <= sat[2];
    g_res_q.on_edge  <= f_side_q.adj & f_edge_q;
    g_res_q.adjusted <= f_side_q.adj;
  end

  assign vld_o = g_vld_q;
  assign res_o = g_res_q;

endmodule
